// ===== sv/ssse3_pkg.sv =====
`default_nettype none
package ssse3_pkg;

  typedef enum logic [3:0] {
    OP_SHUFB    = 4'd0,
    OP_HADDW    = 4'd1,
    OP_HADDD    = 4'd2,
    OP_HADDSW   = 4'd3,
    OP_MADDUBSW = 4'd4,
    OP_HSUBW    = 4'd5,
    OP_HSUBD    = 4'd6,
    OP_HSUBSW   = 4'd7,
    OP_SIGNB    = 4'd8,
    OP_SIGNW    = 4'd9,
    OP_SIGND    = 4'd10,
    OP_MULHRSW  = 4'd11,
    OP_ABSB     = 4'd12,
    OP_ABSW     = 4'd13,
    OP_ABSD     = 4'd14,
    OP_ALIGNR   = 4'd15
  } op_t;

  localparam int NUM_LANES = 4;  // 32-bit lanes across 128 bits

  typedef struct packed {
    logic [3:0]  kind;
    logic        wide;
    logic [63:0] src_low;
    logic [63:0] src_high;
    logic [63:0] dst_low;
    logic [63:0] dst_high;
    logic [7:0]  shift_bytes;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
  } out_item_t;

  function automatic logic [15:0] sat16(input logic signed [17:0] x);
    logic [15:0] r;
    if (x > 18'sd32767) r = 16'h7fff;
    else if (x < -18'sd32768) r = 16'h8000;
    else r = x[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ssse3_packed_integer_alu_top.sv =====
`default_nettype none
// Each accepted transaction's result is registered in the output register or the skid register.
// Throughput: one transaction per cycle while the skid is empty; lanes and merge are one stage.
// One skid register behind the output register takes a transaction while a
// result waits; input stalls while the skid is full.
// Reset (rst, synchronous): clears valid flags; no other state.
module ssse3_packed_integer_alu_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ssse3_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ssse3_pkg::out_item_t      out_data
);
  import ssse3_pkg::*;

  logic [127:0] s, d, lane_res;
  logic [255:0] pairs;
  out_item_t merged, skid;
  logic skid_valid;

  always_comb begin
    s = in_data.wide ? {in_data.src_high, in_data.src_low} : {64'd0, in_data.src_low};
    d = in_data.wide ? {in_data.dst_high, in_data.dst_low} : {64'd0, in_data.dst_low};
    // pair feed: low half of result from dst pairs, high half from src pairs
    if (in_data.wide) pairs = {s, d};
    else pairs = {128'd0, s[63:0], d[63:0]};
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic [31:0] pa, pb;
    always_comb begin
      if (in_data.kind == OP_HADDD || in_data.kind == OP_HSUBD) begin
        pa = pairs[64*g +: 32];
        pb = pairs[64*g+32 +: 32];
      end else begin
        pa = pairs[64*g +: 32];
        pb = pairs[64*g+32 +: 32];
      end
    end
    ssse3_lane u_lane (
      .kind (in_data.kind),
      .s    (s[32*g +: 32]),
      .d    (d[32*g +: 32]),
      .pa   (pa),
      .pb   (pb),
      .res  (lane_res[32*g +: 32])
    );
  end

  ssse3_merge u_merge (.item(in_data), .lane_res(lane_res), .res(merged));

  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_data   <= skid;
          skid_valid <= 1'b0;
          out_valid  <= 1'b1;
        end else begin
          out_data  <= merged;
          out_valid <= in_valid;
        end
      end else if (in_valid && !skid_valid) begin
        skid       <= merged;
        skid_valid <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/ssse3_lane.sv =====
`default_nettype none
// One 32-bit lane: element-wise ops on its own src/dst dword, plus the
// horizontal pair ops on the dword pair (pa, pb) routed to it.
module ssse3_lane (
  input  wire logic [3:0]  kind,
  input  wire logic [31:0] s,
  input  wire logic [31:0] d,
  input  wire logic [31:0] pa,
  input  wire logic [31:0] pb,
  output logic      [31:0] res
);
  import ssse3_pkg::*;

  logic signed [17:0] hw0, hw1;
  logic [31:0] hd;
  logic signed [16:0] m0, m1, m2, m3;
  logic signed [17:0] ms0, ms1;
  logic signed [31:0] mp0, mp1;
  logic [31:0] mr0, mr1;

  always_comb begin
    res = 32'd0;
    hw0 = '0; hw1 = '0; hd = '0;
    m0 = $signed({1'b0, d[7:0]}) * $signed(s[7:0]);
    m1 = $signed({1'b0, d[15:8]}) * $signed(s[15:8]);
    m2 = $signed({1'b0, d[23:16]}) * $signed(s[23:16]);
    m3 = $signed({1'b0, d[31:24]}) * $signed(s[31:24]);
    ms0 = 18'(m0) + 18'(m1);
    ms1 = 18'(m2) + 18'(m3);
    mp0 = $signed(d[15:0]) * $signed(s[15:0]);
    mp1 = $signed(d[31:16]) * $signed(s[31:16]);
    mr0 = 32'(mp0) + 32'h4000;
    mr1 = 32'(mp1) + 32'h4000;
    case (op_t'(kind))
      OP_SHUFB, OP_ALIGNR: res = 32'd0;
      OP_HADDW, OP_HADDSW, OP_HSUBW, OP_HSUBSW: begin
        if (kind[2]) begin
          hw0 = 18'($signed(pa[15:0])) - 18'($signed(pa[31:16]));
          hw1 = 18'($signed(pb[15:0])) - 18'($signed(pb[31:16]));
        end else begin
          hw0 = 18'($signed(pa[15:0])) + 18'($signed(pa[31:16]));
          hw1 = 18'($signed(pb[15:0])) + 18'($signed(pb[31:16]));
        end
        if (kind[1] & kind[0]) res = {sat16(hw1), sat16(hw0)};
        else res = {hw1[15:0], hw0[15:0]};
      end
      OP_HADDD, OP_HSUBD: begin
        hd = kind[2] ? pa - pb : pa + pb;
        res = hd;
      end
      OP_MADDUBSW: res = {sat16(ms1), sat16(ms0)};
      OP_SIGNB:
        for (int k = 0; k < 4; k++)
          res[8*k +: 8] = s[8*k+7] ? 8'(-d[8*k +: 8]) :
                          (s[8*k +: 8] == 8'd0 ? 8'd0 : d[8*k +: 8]);
      OP_SIGNW:
        for (int k = 0; k < 2; k++)
          res[16*k +: 16] = s[16*k+15] ? 16'(-d[16*k +: 16]) :
                            (s[16*k +: 16] == 16'd0 ? 16'd0 : d[16*k +: 16]);
      OP_SIGND: res = s[31] ? -d : (s == 32'd0 ? 32'd0 : d);
      OP_MULHRSW: res = {mr1[30:15], mr0[30:15]};
      OP_ABSB:
        for (int k = 0; k < 4; k++)
          res[8*k +: 8] = s[8*k+7] ? 8'(-s[8*k +: 8]) : s[8*k +: 8];
      OP_ABSW:
        for (int k = 0; k < 2; k++)
          res[16*k +: 16] = s[16*k+15] ? 16'(-s[16*k +: 16]) : s[16*k +: 16];
      OP_ABSD: res = s[31] ? -s : s;
      default: res = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/ssse3_merge.sv =====
`default_nettype none
// Combines lane results with the byte-permute ops (shufb, alignr).
module ssse3_merge (
  input  wire ssse3_pkg::in_item_t item,
  input  wire logic [127:0]        lane_res,
  output ssse3_pkg::out_item_t     res
);
  import ssse3_pkg::*;

  logic [127:0] s, d, r;
  logic [255:0] cat;
  logic [8:0] j;

  always_comb begin
    s = item.wide ? {item.src_high, item.src_low} : {64'd0, item.src_low};
    d = item.wide ? {item.dst_high, item.dst_low} : {64'd0, item.dst_low};
    cat = item.wide ? {d, s} : {128'd0, d[63:0], s[63:0]};
    r = lane_res;
    j = '0;
    if (op_t'(item.kind) == OP_SHUFB) begin
      for (int i = 0; i < 16; i++)
        r[8*i +: 8] = s[8*i+7] ? 8'd0 :
          d[8*(item.wide ? {1'b0, s[8*i +: 4]} : {2'b0, s[8*i +: 3]}) +: 8];
    end else if (op_t'(item.kind) == OP_ALIGNR) begin
      // bytes beyond the concatenation read as zero (upper cat is zero when narrow; j past 31 gives zero)
      for (int i = 0; i < 16; i++) begin
        j = 9'(i) + {1'b0, item.shift_bytes};
        r[8*i +: 8] = j[8:5] != 4'd0 ? 8'd0 : cat[8*j[4:0] +: 8];
      end
    end
    res.result_low  = r[63:0];
    res.result_high = item.wide ? r[127:64] : 64'd0;
  end
endmodule
`default_nettype wire

// ===== sv/ssse3_checker.sv =====
`default_nettype none
module ssse3_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire ssse3_pkg::in_item_t  in_data,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire ssse3_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> out_valid) else $error("latency");
  a_narrow: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !in_data.wide && !out_valid |=> out_data.result_high == 64'd0)
    else $error("narrow high");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("stall without result");
endmodule

bind ssse3_packed_integer_alu_top ssse3_checker u_chk (.*);
`default_nettype wire

// ===== sim/tb_ssse3_packed_integer_alu_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_ssse3_packed_integer_alu_top;
  import ssse3_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  in_item_t pending_ops[$];
  out_item_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int ops_sent = 0;
  int ops_total = 0;
  bit calm_driver = 1'b0;
  bit calm_sink = 1'b0;

  always #1 clk = ~clk;

  ssse3_packed_integer_alu_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function automatic logic [15:0] clamp_word(longint x);
    if (x > 32767) return 16'h7fff;
    if (x < -32768) return 16'h8000;
    return x[15:0];
  endfunction

  function automatic longint lane_signed(logic [127:0] v, int idx, int sz);
    logic [31:0] raw;
    raw = 32'((v >> (idx * sz * 8)) & ((64'd1 << (sz * 8)) - 1));
    case (sz)
      1: return longint'($signed(raw[7:0]));
      2: return longint'($signed(raw[15:0]));
      default: return longint'($signed(raw[31:0]));
    endcase
  endfunction

  function automatic logic [31:0] lane_raw(logic [127:0] v, int idx, int sz);
    return 32'((v >> (idx * sz * 8)) & ((64'd1 << (sz * 8)) - 1));
  endfunction

  function automatic out_item_t compute_simd(in_item_t it);
    logic [127:0] s, d, r;
    logic [255:0] cat;
    out_item_t o;
    int nb, sz, half;
    longint a, b, x, c;
    logic [31:0] v;
    logic [7:0] ctl;
    op_t op;
    nb = it.wide ? 16 : 8;
    s = it.wide ? {it.src_high, it.src_low} : {64'd0, it.src_low};
    d = it.wide ? {it.dst_high, it.dst_low} : {64'd0, it.dst_low};
    r = '0;
    op = op_t'(it.kind);
    case (op)
      OP_SHUFB: begin
        for (int i = 0; i < nb; i++) begin
          ctl = s[i*8 +: 8];
          if (!ctl[7]) r[i*8 +: 8] = d[(it.wide ? ctl[3:0] : ctl[2:0]) * 8 +: 8];
        end
      end
      OP_HADDW, OP_HADDD, OP_HADDSW, OP_HSUBW, OP_HSUBD, OP_HSUBSW: begin
        sz = (op == OP_HADDD || op == OP_HSUBD) ? 4 : 2;
        half = nb / sz / 2;
        for (int i = 0; i < 2 * half; i++) begin
          a = lane_signed(i < half ? d : s, 2 * (i % half), sz);
          b = lane_signed(i < half ? d : s, 2 * (i % half) + 1, sz);
          x = (op >= OP_HSUBW) ? a - b : a + b;
          if (op == OP_HADDSW || op == OP_HSUBSW) r[i*16 +: 16] = clamp_word(x);
          else if (sz == 2) r[i*16 +: 16] = x[15:0];
          else r[i*32 +: 32] = x[31:0];
        end
      end
      OP_MADDUBSW: begin
        for (int i = 0; i < nb / 2; i++) begin
          x = longint'(d[16*i +: 8]) * lane_signed(s, 2 * i, 1)
            + longint'(d[16*i+8 +: 8]) * lane_signed(s, 2 * i + 1, 1);
          r[i*16 +: 16] = clamp_word(x);
        end
      end
      OP_SIGNB, OP_SIGNW, OP_SIGND: begin
        sz = 1 << (it.kind - OP_SIGNB);
        for (int i = 0; i < nb / sz; i++) begin
          c = lane_signed(s, i, sz);
          v = lane_raw(d, i, sz);
          if (c < 0) v = -v;
          else if (c == 0) v = 0;
          for (int k = 0; k < sz; k++) r[(i*sz+k)*8 +: 8] = v[k*8 +: 8];
        end
      end
      OP_MULHRSW: begin
        for (int i = 0; i < nb / 2; i++) begin
          x = lane_signed(d, i, 2) * lane_signed(s, i, 2);
          x = ((x >>> 14) + 1) >>> 1;
          r[i*16 +: 16] = x[15:0];
        end
      end
      OP_ABSB, OP_ABSW, OP_ABSD: begin
        sz = 1 << (it.kind - OP_ABSB);
        for (int i = 0; i < nb / sz; i++) begin
          v = lane_raw(s, i, sz);
          if (lane_signed(s, i, sz) < 0) v = -v;
          for (int k = 0; k < sz; k++) r[(i*sz+k)*8 +: 8] = v[k*8 +: 8];
        end
      end
      default: begin
        cat = it.wide ? {d, s} : {128'd0, d[63:0], s[63:0]};
        for (int i = 0; i < nb; i++)
          if (i + it.shift_bytes < 2 * nb) r[i*8 +: 8] = cat[(i + it.shift_bytes) * 8 +: 8];
      end
    endcase
    o.result_low = r[63:0];
    o.result_high = it.wide ? r[127:64] : 64'd0;
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = {4{16'h8000}};
      3: v = {8{8'h7f}};
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_op(op_t op, bit wide, logic [63:0] sl, logic [63:0] sh,
                          logic [63:0] dl, logic [63:0] dh, logic [7:0] cnt);
    in_item_t it;
    it.kind = op;
    it.wide = wide;
    it.src_low = sl;
    it.src_high = sh;
    it.dst_low = dl;
    it.dst_high = dh;
    it.shift_bytes = cnt;
    pending_ops.push_back(it);
  endtask

  // driver: next transaction is presented at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() > 0 && (calm_driver || $urandom_range(0, 99) >= 30)) begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !calm_sink && ($urandom_range(0, 99) < 30);
    end
  end

  // monitor: accepted transactions at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(compute_simd(in_data));
        ops_sent++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          want = expected_results.pop_front();
          if (want.result_low !== out_data.result_low ||
              want.result_high !== out_data.result_high) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h_%h got %h_%h", want.result_high,
                       want.result_low, out_data.result_high, out_data.result_low);
          end
        end
      end
    end
  end

  initial begin
    op_t op;
    for (int k = 0; k < 16; k++) begin
      op = op_t'(k);
      queue_op(op, k[0], '1, {4{16'h8000}}, {8{8'h7f}}, '1, 8'd0);
      queue_op(op, ~k[0], {8{8'h80}}, 64'h0001_ffff_7fff_8000, '0, {8{8'h80}}, 8'd255);
    end
    // align right counts around the concatenation edges
    queue_op(OP_ALIGNR, 1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, '1, 64'h55, 8'd31);
    queue_op(OP_ALIGNR, 1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, '1, 64'h55, 8'd32);
    queue_op(OP_ALIGNR, 1'b0, 64'h0123456789abcdef, 64'h0, '1, 64'h0, 8'd15);
    queue_op(OP_ALIGNR, 1'b0, 64'h0123456789abcdef, 64'h0, '1, 64'h0, 8'd16);
    queue_op(OP_ALIGNR, 1'b0, 64'h0123456789abcdef, 64'h0, 64'h1122, 64'h0, 8'd8);
    repeat (1200) begin
      queue_op(op_t'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), rand64(), rand64(),
               rand64(), rand64(),
               $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 33)));
    end
    ops_total = pending_ops.size();
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    wait (pending_ops.size() < 800);
    calm_driver = 1'b1;
    calm_sink = 1'b1;
    wait (pending_ops.size() < 600);
    calm_driver = 1'b0;
    calm_sink = 1'b0;
    wait (results_seen >= ops_total);
    repeat (10) @(posedge clk);
    $display("covered %0d operations over all 16 kinds, both widths, %0d results checked",
             ops_sent, results_seen);
    if (mismatches == 0 && expected_results.size() == 0 && ops_sent == ops_total) begin
      $display("PASS ssse3_packed_integer_alu_top");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("FAIL ssse3_packed_integer_alu_top");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("timeout");
    $display("FAIL ssse3_packed_integer_alu_top");
    $finish;
  end

endmodule
`default_nettype wire
